// File: design/stsum_pkg.sv
// Package for the segment tree range sum core: item types, op codes and
// field widths. Used by stsum_walk and segment_tree_point_update_range_sum_core.
package stsum_pkg;

  localparam int IDX_W = 10;
  localparam int VAL_W = 32;
  localparam int SUM_W = 48;
  localparam int CNT_W = 11;

  localparam logic [CNT_W-1:0] ELEM_COUNT_RESET = 11'd1024;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_TAKE  = 2'd1,
    OP_ADD   = 2'd2,
    OP_RANGE = 2'd3
  } stsum_op_e;

  typedef struct packed {
    stsum_op_e         op;
    logic [IDX_W-1:0]  index;
    logic [IDX_W-1:0]  index_hi;
    logic [VAL_W-1:0]  value;
  } stsum_in_t;

  typedef struct packed {
    logic [SUM_W-1:0]  sum;
    logic              out_of_range;
  } stsum_out_t;

  // Walker status toward the top level
  typedef struct packed {
    logic ready;
    logic done;
  } stsum_stat_t;

endpackage

// File: design/stsum_walk.sv
// Tree walker: node sum memory plus the sequencer for updates and range sums.
// Depends on stsum_pkg.
module stsum_walk import stsum_pkg::*; #(
  parameter int LEAVES = 1024
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  stsum_in_t        req_i,
  input  logic [CNT_W-1:0] count_i,
  input  logic             res_ack_i,
  output stsum_stat_t      stat_o,
  output stsum_out_t       res_o
);

  localparam int NODES = 2 * LEAVES;
  localparam int AW    = $clog2(NODES);
  localparam int XW    = ((AW + 1 > IDX_W) ? AW + 1 : IDX_W) + 1;
  localparam logic [XW-1:0] LEAF_BASE = XW'(LEAVES);
  localparam logic [AW-1:0] LAST_NODE = AW'(NODES - 1);
  localparam logic [AW-1:0] ROOT      = AW'(1);

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LEAF_RD,
    ST_LEAF_WR,
    ST_PARENT,
    ST_RS_TEST,
    ST_RS_LEFT,
    ST_RS_RIGHT,
    ST_FINISH
  } state_e;

  // Node sum memory, one write and one read port
  logic [SUM_W-1:0] mem [NODES];
  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  logic [SUM_W-1:0] mem_wdata;
  logic             mem_re;
  logic [AW-1:0]    mem_raddr;
  logic [SUM_W-1:0] rdata_q;

  state_e           state_q, state_d;
  logic [AW-1:0]    clr_q, clr_d;
  logic [AW-1:0]    pos_q, pos_d;
  logic [AW:0]      l_q, l_d;
  logic [AW:0]      r_q, r_d;
  logic [SUM_W-1:0] cur_q, cur_d;
  logic [SUM_W-1:0] sum_q, sum_d;
  logic             acc_q, acc_d;
  logic             oor_q, oor_d;
  stsum_op_e        op_q, op_d;
  logic [VAL_W-1:0] val_q, val_d;

  logic [XW-1:0]    leaf_lo_x, leaf_hi_x;
  logic             lo_oor, hi_oor, req_oor;
  logic [SUM_W-1:0] leaf_new, par_sum;
  logic [AW-1:0]    pos_up;
  logic [AW:0]      r_dec, r_sel;

  // Leaf positions and range checks of the incoming item
  assign leaf_lo_x = XW'(req_i.index) + LEAF_BASE;
  assign leaf_hi_x = XW'(req_i.index_hi) + LEAF_BASE;
  assign lo_oor    = ({1'b0, req_i.index} >= count_i) || (32'(req_i.index) >= 32'(LEAVES));
  assign hi_oor    = ({1'b0, req_i.index_hi} >= count_i)
                     || (32'(req_i.index_hi) >= 32'(LEAVES));
  assign req_oor   = lo_oor || ((req_i.op == OP_RANGE) && hi_oor);

  assign par_sum = cur_q + rdata_q;
  assign pos_up  = pos_q >> 1;
  assign r_dec   = r_q - 1'b1;
  assign r_sel   = r_q[0] ? r_dec : r_q;

  // New leaf value from the old one
  always_comb begin
    case (op_q)
      OP_LOAD: leaf_new = SUM_W'(val_q);
      OP_TAKE: leaf_new = '0;
      OP_ADD:  leaf_new = rdata_q + SUM_W'(val_q);
      default: leaf_new = rdata_q;
    endcase
  end

  // Sequencer next state and memory port control
  always_comb begin
    state_d   = state_q;
    clr_d     = clr_q;
    pos_d     = pos_q;
    l_d       = l_q;
    r_d       = r_q;
    cur_d     = cur_q;
    sum_d     = acc_q ? (sum_q + rdata_q) : sum_q;
    acc_d     = 1'b0;
    oor_d     = oor_q;
    op_d      = op_q;
    val_d     = val_q;
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = '0;
    mem_re    = 1'b0;
    mem_raddr = '0;

    unique case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        clr_d     = clr_q + 1'b1;
        if (clr_q == LAST_NODE) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start_i) begin
          op_d  = req_i.op;
          val_d = req_i.value;
          pos_d = leaf_lo_x[AW-1:0];
          l_d   = leaf_lo_x[AW:0];
          r_d   = leaf_hi_x[AW:0] + 1'b1;
          sum_d = '0;
          oor_d = req_oor;
          if (req_oor) begin
            state_d = ST_FINISH;
          end else if (req_i.op == OP_RANGE) begin
            state_d = (req_i.index > req_i.index_hi) ? ST_FINISH : ST_RS_TEST;
          end else begin
            state_d = ST_LEAF_RD;
          end
        end
      end
      ST_LEAF_RD: begin
        mem_re    = 1'b1;
        mem_raddr = pos_q;
        state_d   = ST_LEAF_WR;
      end
      ST_LEAF_WR: begin
        // Write the leaf, fetch its sibling
        mem_we    = 1'b1;
        mem_waddr = pos_q;
        mem_wdata = leaf_new;
        cur_d     = leaf_new;
        if (op_q == OP_TAKE) begin
          sum_d = rdata_q;
        end
        mem_re    = 1'b1;
        mem_raddr = pos_q ^ AW'(1);
        state_d   = ST_PARENT;
      end
      ST_PARENT: begin
        // Write the parent, fetch the parent's sibling
        mem_we    = 1'b1;
        mem_waddr = pos_up;
        mem_wdata = par_sum;
        cur_d     = par_sum;
        pos_d     = pos_up;
        if (pos_up == ROOT) begin
          state_d = ST_FINISH;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = pos_up ^ AW'(1);
        end
      end
      ST_RS_TEST: begin
        state_d = (l_q < r_q) ? ST_RS_LEFT : ST_FINISH;
      end
      ST_RS_LEFT: begin
        if (l_q[0]) begin
          mem_re    = 1'b1;
          mem_raddr = l_q[AW-1:0];
          l_d       = l_q + 1'b1;
          acc_d     = 1'b1;
        end
        state_d = ST_RS_RIGHT;
      end
      ST_RS_RIGHT: begin
        if (r_q[0]) begin
          mem_re    = 1'b1;
          mem_raddr = r_dec[AW-1:0];
          acc_d     = 1'b1;
        end
        r_d     = r_sel >> 1;
        l_d     = l_q >> 1;
        state_d = ST_RS_TEST;
      end
      ST_FINISH: begin
        if (res_ack_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Hold state and working registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
      acc_q   <= 1'b0;
      pos_q   <= '0;
      l_q     <= '0;
      r_q     <= '0;
      cur_q   <= '0;
      sum_q   <= '0;
      oor_q   <= 1'b0;
      op_q    <= OP_LOAD;
      val_q   <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      acc_q   <= acc_d;
      pos_q   <= pos_d;
      l_q     <= l_d;
      r_q     <= r_d;
      cur_q   <= cur_d;
      sum_q   <= sum_d;
      oor_q   <= oor_d;
      op_q    <= op_d;
      val_q   <= val_d;
    end
  end

  // Memory ports, registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem[mem_raddr];
    end
  end

  assign stat_o.ready       = (state_q == ST_IDLE);
  assign stat_o.done        = (state_q == ST_FINISH);
  assign res_o.sum          = oor_q ? '0 : sum_q;
  assign res_o.out_of_range = oor_q;

endmodule

// File: design/segment_tree_point_update_range_sum_core.sv
// Top level of the segment tree range sum core: handshakes, count register,
// result register. Depends on stsum_pkg and stsum_walk.
//
//   channel  direction  handshake                 payload
//   in       input      in_valid_i / in_stall_o   in_item_i  (stsum_in_t)
//   out      output     out_valid_o / out_stall_i out_item_o (stsum_out_t)
//   cfg      input      cfg_valid_i / cfg_ready_o cfg_data_i (element_count)
//
// After reset the node memory is swept to zero, one node a cycle, with
// in_stall_o high throughout. Load, take and add make one memory write per
// tree level on the way to the root; a range sum is bound by the one read
// port. Out-of-range and empty-range items go straight to the finish state.
// One item is in work at a time; a finished item waits in the result
// register while the next one is accepted, and out_stall_i holds the walker
// only when that register is still occupied.
module segment_tree_point_update_range_sum_core import stsum_pkg::*; #(
  parameter int LEAVES = 1024
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  stsum_in_t        in_item_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output stsum_out_t       out_item_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [CNT_W-1:0] cfg_data_i
);

  logic [CNT_W-1:0] count_q, count_d;
  logic             out_valid_q, out_valid_d;
  stsum_out_t       out_item_q, out_item_d;
  stsum_stat_t      stat;
  stsum_out_t       res;
  logic             start;
  logic             slot_free;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = !stat.ready;
  assign start       = in_valid_i && stat.ready;
  assign slot_free   = !out_valid_q || !out_stall_i;

  stsum_walk #(
    .LEAVES(LEAVES)
  ) u_walk (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .req_i    (in_item_i),
    .count_i  (count_q),
    .res_ack_i(slot_free),
    .stat_o   (stat),
    .res_o    (res)
  );

  // Count register and result register
  always_comb begin
    count_d     = count_q;
    out_valid_d = out_valid_q;
    out_item_d  = out_item_q;
    if (cfg_valid_i && cfg_ready_o) begin
      count_d = cfg_data_i;
    end
    if (stat.done && slot_free) begin
      out_valid_d = 1'b1;
      out_item_d  = res;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= ELEM_COUNT_RESET;
      out_valid_q <= 1'b0;
      out_item_q  <= '0;
    end else begin
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      out_item_q  <= out_item_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

`ifndef SYNTHESIS
  // An accepted item keeps the walker busy in the next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input accepted twice in a row");

  // A finished item with a free slot shows up on the output
  a_result_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (stat.done && slot_free) |=> out_valid_o)
    else $error("finished item not loaded into result register");

  // Out-of-range items carry a zero sum
  a_oor_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_item_o.out_of_range) |-> (out_item_o.sum == '0))
    else $error("out-of-range item with nonzero sum");
`endif

endmodule
